// File: design/psc_pkg.sv
// shared constants, codes and control/status types of the scrollback compositor
package psc_pkg;

  localparam int RING_DEPTH_DEF     = 50;
  localparam int SLOT_BYTES_DEF     = 256;
  localparam int SCREEN_COLUMNS_DEF = 132;
  localparam int SCREEN_ROWS        = 32;
  localparam int PAGE_COUNT         = 4;

  typedef enum logic [1:0] {
    CMD_HEADER = 2'd0,
    CMD_DATA   = 2'd1,
    CMD_RENDER = 2'd2,
    CMD_READ   = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    ST_ACCEPTED  = 3'd0,
    ST_PUBLISHED = 3'd1,
    ST_REJECTED  = 3'd2,
    ST_RENDERED  = 3'd3,
    ST_READ_DATA = 3'd4
  } status_t;

  typedef struct packed {
    logic signed [15:0] x;
    logic [7:0]         w;
    logic [7:0]         h;
    logic [8:0]         p;
  } slot_meta_t;

  typedef struct packed {
    logic accept;
    logic clr_step;
    logic meta_rd;
    logic setup1;
    logic setup2;
    logic setup3;
    logic row_ld;
    logic pix_step;
    logic row_next;
    logic frame_next;
    logic emit_render;
    logic emit_read;
  } psc_cmd_t;

  typedef struct packed {
    logic out_free;
    logic clr_last;
    logic loop_go;
    logic draw_ok;
    logic pix_last;
    logic row_last;
  } psc_sts_t;

endpackage

// File: design/psc_ctrl.sv
// sequencer that steps the datapath through commands and the render walk
module psc_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic [1:0]          in_cmd,
  output logic                in_ready,
  output psc_pkg::psc_cmd_t   cmd,
  input  psc_pkg::psc_sts_t   sts
);
  import psc_pkg::*;

  typedef enum logic [10:0] {
    S_IDLE = 11'b00000000001,
    S_CLR  = 11'b00000000010,
    S_CHK  = 11'b00000000100,
    S_SU1  = 11'b00000001000,
    S_SU2  = 11'b00000010000,
    S_SU3  = 11'b00000100000,
    S_ROW  = 11'b00001000000,
    S_PIX  = 11'b00010000000,
    S_RNXT = 11'b00100000000,
    S_FNXT = 11'b01000000000,
    S_READ = 11'b10000000000
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = sts.out_free;
        if (in_valid && sts.out_free) begin
          cmd.accept = 1'b1;
          if (in_cmd == CMD_RENDER) state_nxt = S_CLR;
          else if (in_cmd == CMD_READ) state_nxt = S_READ;
        end
      end
      S_CLR: begin
        cmd.clr_step = 1'b1;
        if (sts.clr_last) state_nxt = S_CHK;
      end
      S_CHK: begin
        if (sts.loop_go) begin
          cmd.meta_rd = 1'b1;
          state_nxt   = S_SU1;
        end else begin
          cmd.emit_render = 1'b1;
          state_nxt       = S_IDLE;
        end
      end
      S_SU1: begin
        cmd.setup1 = 1'b1;
        state_nxt  = S_SU2;
      end
      S_SU2: begin
        cmd.setup2 = 1'b1;
        state_nxt  = S_SU3;
      end
      S_SU3: begin
        cmd.setup3 = 1'b1;
        state_nxt  = sts.draw_ok ? S_ROW : S_FNXT;
      end
      S_ROW: begin
        cmd.row_ld = 1'b1;
        state_nxt  = S_PIX;
      end
      S_PIX: begin
        cmd.pix_step = 1'b1;
        if (sts.pix_last) state_nxt = S_RNXT;
      end
      S_RNXT: begin
        cmd.row_next = 1'b1;
        state_nxt    = sts.row_last ? S_FNXT : S_ROW;
      end
      S_FNXT: begin
        cmd.frame_next = 1'b1;
        state_nxt      = S_CHK;
      end
      S_READ: begin
        cmd.emit_read = 1'b1;
        state_nxt     = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else        state_r <= state_nxt;
  end

endmodule

// File: design/psc_dp.sv
// ring bookkeeping, bitmap and frame buffer memories, render pixel pipeline
module psc_dp #(
  parameter int RING_DEPTH     = psc_pkg::RING_DEPTH_DEF,
  parameter int SLOT_BYTES     = psc_pkg::SLOT_BYTES_DEF,
  parameter int SCREEN_COLUMNS = psc_pkg::SCREEN_COLUMNS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  psc_pkg::psc_cmd_t  cmd,
  output psc_pkg::psc_sts_t  sts,
  input  logic [1:0]         in_cmd,
  input  logic signed [15:0] in_x_offset,
  input  logic [7:0]         in_frame_width,
  input  logic [7:0]         in_frame_height,
  input  logic [8:0]         in_bytes_per_line,
  input  logic [7:0]         in_data_byte,
  input  logic [13:0]        in_scroll_rows,
  input  logic               in_shift,
  input  logic [9:0]         in_read_index,
  input  logic               out_ready,
  output logic               out_valid,
  output logic [2:0]         out_status,
  output logic               out_dropped_oldest,
  output logic               out_any_printed,
  output logic               out_at_top,
  output logic [7:0]         out_frame_byte
);
  import psc_pkg::*;

  localparam int SW          = $clog2(RING_DEPTH);
  localparam int CW          = $clog2(RING_DEPTH + 1);
  localparam int NW          = $clog2(SLOT_BYTES + 1);
  localparam int SBW         = $clog2(SLOT_BYTES);
  localparam int STORE_DEPTH = RING_DEPTH * SLOT_BYTES;
  localparam int STORE_AW    = $clog2(STORE_DEPTH);
  localparam int FB_DEPTH    = PAGE_COUNT * SCREEN_COLUMNS;
  localparam int FB_AW       = $clog2(FB_DEPTH);

  // memories
  logic [7:0]  store_mem [STORE_DEPTH];
  slot_meta_t  meta_mem  [RING_DEPTH];
  logic [7:0]  fb_mem    [FB_DEPTH];
  logic [7:0]  store_q_r, fb_q_r;
  slot_meta_t  meta_q_r;

  // ring state
  logic [SW-1:0]       wslot_r, oldest_r;
  logic [STORE_AW-1:0] wbase_r;
  logic [CW-1:0]       count_r;
  logic [NW-1:0]       exp_r, rcv_r;
  logic                drop_r, fb_clean_r, out_valid_r;

  // render walk
  logic [13:0]         off_r;
  logic                shift_r, top_r, ri_ok_r;
  logic [15:0]         rows_r;
  logic [CW-1:0]       left_r;
  logic [SW-1:0]       rslot_r;
  logic [FB_AW-1:0]    clr_cnt_r;
  logic signed [17:0]  y0_r, dxb_r;
  logic                hit_r, draw_ok_r;
  logic [7:0]          sxo_r, sy_start_r, sy_end_r, sy_r;
  logic [8:0]          span_r, sx_r;
  logic [STORE_AW-1:0] sbase_r;
  logic [15:0]         rowb_r;
  logic [FB_AW-1:0]    page_base_r;
  logic [7:0]          mask_r;

  // pixel pipeline
  logic                p1_v_r, p1_ok_r, w_v_r;
  logic [2:0]          p1_bit_r;
  logic [FB_AW-1:0]    p1_addr_r, w_addr_r;
  logic [7:0]          p1_mask_r, w_data_r;

  // output word
  logic [2:0] out_status_r;
  logic       out_drop_r, out_any_r, out_top_r;
  logic [7:0] out_byte_r;

  // combinational
  logic                is_hdr, is_dat, is_ren, is_rd;
  logic [16:0]         hdr_n;
  logic                hdr_ok, hdr_take, do_drop, dat_go, dat_last, out_load;
  logic signed [17:0]  dx_s, start_s, end_s, lim_s, hm1_s;
  logic [17:0]         dx_u;
  logic                vis, on_ok, px_on;
  logic [8:0]          col;
  logic [5:0]          bc;
  logic [16:0]         pos;
  logic [STORE_AW-1:0] st_ra, st_wa;
  logic [FB_AW-1:0]    fb_pa, fb_ra, fb_wa;
  logic [7:0]          fb_wd, old_b, new_b;
  logic                fb_we;
  logic [4:0]          dy5;
  logic [8:0]          dx_off;
  slot_meta_t          hdr_meta;

  always_comb begin
    is_hdr   = cmd.accept && (in_cmd == CMD_HEADER);
    is_dat   = cmd.accept && (in_cmd == CMD_DATA);
    is_ren   = cmd.accept && (in_cmd == CMD_RENDER);
    is_rd    = cmd.accept && (in_cmd == CMD_READ);
    hdr_n    = 17'(in_bytes_per_line) * 17'(in_frame_height);
    hdr_ok   = (in_frame_width != '0) && (in_frame_height != '0) &&
               (in_bytes_per_line != '0) && (hdr_n <= 17'(SLOT_BYTES));
    hdr_take = is_hdr && hdr_ok;
    do_drop  = hdr_take && (exp_r == '0) && (count_r >= CW'(RING_DEPTH));
    dat_go   = is_dat && (exp_r != '0);
    dat_last = dat_go && ((rcv_r + NW'(1)) == exp_r);
    out_load = is_hdr || is_dat || cmd.emit_render || cmd.emit_read;
    hdr_meta = '{x: in_x_offset, w: in_frame_width, h: in_frame_height,
                 p: in_bytes_per_line};
    st_wa    = wbase_r + STORE_AW'(rcv_r);

    dx_off   = (SCREEN_COLUMNS > int'(meta_q_r.w)) ?
               9'(SCREEN_COLUMNS - int'(meta_q_r.w)) : 9'd0;
    hm1_s    = $signed({10'b0, meta_q_r.h}) - 18'sd1;
    lim_s    = 18'sd31 - y0_r;
    start_s  = y0_r[17] ? -y0_r : 18'sd0;
    end_s    = (hm1_s < lim_s) ? hm1_s : lim_s;
    dy5      = y0_r[4:0] + sy_r[4:0];

    // pixel stage 0: coordinates and addresses
    dx_s     = dxb_r + $signed({9'b0, sx_r});
    dx_u     = dx_s;
    vis      = !dx_s[17] && (dx_s < $signed(18'(SCREEN_COLUMNS)));
    col      = sx_r + 9'(sxo_r);
    bc       = col[8:3];
    pos      = 17'(rowb_r) + 17'(bc);
    on_ok    = (9'(bc) < meta_q_r.p) && (pos < 17'(SLOT_BYTES));
    st_ra    = on_ok ? (sbase_r + STORE_AW'(pos[SBW-1:0])) : sbase_r;
    fb_pa    = page_base_r + dx_u[FB_AW-1:0];
    fb_ra    = cmd.pix_step ? fb_pa : in_read_index[FB_AW-1:0];

    // pixel stage 1: merge with a write that raced the read
    old_b    = (w_v_r && (w_addr_r == p1_addr_r)) ? w_data_r : fb_q_r;
    px_on    = p1_ok_r && store_q_r[p1_bit_r];
    new_b    = px_on ? (old_b | p1_mask_r) : (old_b & ~p1_mask_r);

    fb_we    = cmd.clr_step || p1_v_r;
    fb_wa    = cmd.clr_step ? clr_cnt_r : p1_addr_r;
    fb_wd    = cmd.clr_step ? 8'd0 : new_b;

    sts.out_free = !out_valid_r || out_ready;
    sts.clr_last = (clr_cnt_r == FB_AW'(FB_DEPTH - 1));
    sts.loop_go  = (left_r != '0) &&
                   (17'(rows_r) < (17'(off_r) + 17'(SCREEN_ROWS)));
    sts.draw_ok  = draw_ok_r;
    sts.pix_last = (sx_r == (span_r - 9'd1));
    sts.row_last = (sy_r == sy_end_r);
  end

  // memories
  always_ff @(posedge clk) begin
    if (dat_go) store_mem[st_wa] <= in_data_byte;
    store_q_r <= store_mem[st_ra];
    if (hdr_take) meta_mem[wslot_r] <= hdr_meta;
    if (cmd.meta_rd) meta_q_r <= meta_mem[rslot_r];
    if (fb_we) fb_mem[fb_wa] <= fb_wd;
    fb_q_r <= fb_mem[fb_ra];
  end

  // ring and handshake state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wslot_r     <= '0;
      wbase_r     <= '0;
      oldest_r    <= '0;
      count_r     <= '0;
      exp_r       <= '0;
      rcv_r       <= '0;
      drop_r      <= 1'b0;
      fb_clean_r  <= 1'b1;
      out_valid_r <= 1'b0;
      p1_v_r      <= 1'b0;
      w_v_r       <= 1'b0;
    end else begin
      if (hdr_take) begin
        exp_r <= NW'(hdr_n);
        rcv_r <= '0;
      end
      if (do_drop) begin
        oldest_r <= (oldest_r == SW'(RING_DEPTH - 1)) ? '0 : oldest_r + SW'(1);
        count_r  <= count_r - CW'(1);
        drop_r   <= 1'b1;
      end
      if (dat_go) begin
        if (dat_last) begin
          exp_r   <= '0;
          rcv_r   <= '0;
          drop_r  <= 1'b0;
          count_r <= count_r + CW'(1);
          if (wslot_r == SW'(RING_DEPTH - 1)) begin
            wslot_r <= '0;
            wbase_r <= '0;
          end else begin
            wslot_r <= wslot_r + SW'(1);
            wbase_r <= wbase_r + STORE_AW'(SLOT_BYTES);
          end
        end else begin
          rcv_r <= rcv_r + NW'(1);
        end
      end
      if (is_ren) fb_clean_r <= 1'b0;
      if (out_load)       out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
      p1_v_r <= cmd.pix_step && vis;
      w_v_r  <= p1_v_r;
    end
  end

  // render walk and pipeline payload
  always_ff @(posedge clk) begin
    if (is_ren) begin
      off_r     <= in_scroll_rows;
      shift_r   <= in_shift;
      rows_r    <= '0;
      left_r    <= count_r;
      rslot_r   <= (wslot_r == '0) ? SW'(RING_DEPTH - 1) : wslot_r - SW'(1);
      top_r     <= 1'b1;
      clr_cnt_r <= '0;
    end
    if (is_rd) ri_ok_r <= (11'(in_read_index) < 11'(FB_DEPTH));
    if (cmd.clr_step) clr_cnt_r <= clr_cnt_r + FB_AW'(1);
    if (cmd.setup1) begin
      y0_r    <= 18'sd31 + $signed({4'b0, off_r}) - $signed({2'b0, rows_r})
                 - $signed({10'b0, meta_q_r.h});
      hit_r   <= (17'(rows_r) + 17'(meta_q_r.h)) >= 17'(off_r);
      dxb_r   <= $signed({{2{meta_q_r.x[15]}}, meta_q_r.x}) + $signed({9'b0, dx_off});
      sxo_r   <= (!shift_r && (int'(meta_q_r.w) > SCREEN_COLUMNS)) ?
                 8'(int'(meta_q_r.w) - SCREEN_COLUMNS) : 8'd0;
      span_r  <= (int'(meta_q_r.w) < SCREEN_COLUMNS) ? 9'(meta_q_r.w) :
                 9'(SCREEN_COLUMNS);
      sbase_r <= STORE_AW'(rslot_r * SLOT_BYTES);
    end
    if (cmd.setup2) begin
      sy_start_r <= start_s[7:0];
      sy_end_r   <= end_s[7:0];
      draw_ok_r  <= hit_r && (start_s <= end_s);
    end
    if (cmd.setup3) begin
      rowb_r <= 16'(sy_start_r) * 16'(meta_q_r.p);
      sy_r   <= sy_start_r;
    end
    if (cmd.row_ld) begin
      page_base_r <= FB_AW'(dy5[4:3] * SCREEN_COLUMNS);
      mask_r      <= 8'b1 << dy5[2:0];
      sx_r        <= '0;
    end
    if (cmd.pix_step) sx_r <= sx_r + 9'd1;
    if (cmd.row_next) begin
      sy_r   <= sy_r + 8'd1;
      rowb_r <= rowb_r + 16'(meta_q_r.p);
    end
    if (cmd.frame_next) begin
      rows_r  <= rows_r + 16'(meta_q_r.h);
      left_r  <= left_r - CW'(1);
      rslot_r <= (rslot_r == '0) ? SW'(RING_DEPTH - 1) : rslot_r - SW'(1);
      if (hit_r) top_r <= 1'b0;
    end
    p1_ok_r   <= on_ok;
    p1_bit_r  <= col[2:0];
    p1_addr_r <= fb_pa;
    p1_mask_r <= mask_r;
    w_addr_r  <= p1_addr_r;
    w_data_r  <= new_b;

    if (out_load) begin
      out_status_r <= ST_ACCEPTED;
      out_drop_r   <= 1'b0;
      out_any_r    <= 1'b0;
      out_top_r    <= 1'b0;
      out_byte_r   <= 8'd0;
      if (is_hdr && !hdr_ok) out_status_r <= ST_REJECTED;
      if (dat_last) begin
        out_status_r <= ST_PUBLISHED;
        out_drop_r   <= drop_r;
      end
      if (cmd.emit_render) begin
        out_status_r <= ST_RENDERED;
        out_any_r    <= (count_r != '0);
        out_top_r    <= top_r;
      end
      if (cmd.emit_read) begin
        out_status_r <= ST_READ_DATA;
        out_byte_r   <= (ri_ok_r && !fb_clean_r) ? fb_q_r : 8'd0;
      end
    end
  end

  assign out_valid          = out_valid_r;
  assign out_status         = out_status_r;
  assign out_dropped_oldest = out_drop_r;
  assign out_any_printed    = out_any_r;
  assign out_at_top         = out_top_r;
  assign out_frame_byte     = out_byte_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(RING_DEPTH))
    else $error("stored count above ring depth");

  a_ring_consistent: assert property (@(posedge clk) disable iff (!rst_n)
    (32'(oldest_r) + 32'(count_r) == 32'(wslot_r)) ||
    (32'(oldest_r) + 32'(count_r) == 32'(wslot_r) + 32'(RING_DEPTH)))
    else $error("write slot out of step with oldest plus count");

  a_idle_rcv: assert property (@(posedge clk) disable iff (!rst_n)
    (exp_r == '0) |-> (rcv_r == '0))
    else $error("bytes received with no header pending");

  a_no_write_clash: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.clr_step && p1_v_r))
    else $error("pixel write during frame buffer clear");

endmodule

// File: design/printout_scrollback_compositor.sv
// top level of the printout scrollback compositor: sequencer plus datapath
// Keeps a ring of RING_DEPTH printout bitmaps of up to SLOT_BYTES bytes each and composes
// them into a 32-row, SCREEN_COLUMNS-wide page-organized frame buffer. Every command word
// gives exactly one result word. Header and data words are answered when they are accepted,
// a read from S_READ once the registered frame buffer read port has returned its byte. A
// render first clears all 4*SCREEN_COLUMNS frame buffer bytes one byte per cycle in S_CLR,
// then visits stored frames through S_CHK, S_SU1, S_SU2, S_SU3 and S_FNXT; for each visible
// screen row it passes S_ROW, the S_PIX loop over min(width, SCREEN_COLUMNS) pixels doing
// one frame buffer read-modify-write per cycle, and S_RNXT; S_CHK posts the result at the end.
// The block takes one word at a time; a new word is accepted only when the output register
// is empty or its result is taken in the same cycle. Frame buffer reads before the
// first render return zero.
module printout_scrollback_compositor #(
  parameter int RING_DEPTH     = psc_pkg::RING_DEPTH_DEF,
  parameter int SLOT_BYTES     = psc_pkg::SLOT_BYTES_DEF,
  parameter int SCREEN_COLUMNS = psc_pkg::SCREEN_COLUMNS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         in_cmd,
  input  logic signed [15:0] in_x_offset,
  input  logic [7:0]         in_frame_width,
  input  logic [7:0]         in_frame_height,
  input  logic [8:0]         in_bytes_per_line,
  input  logic [7:0]         in_data_byte,
  input  logic [13:0]        in_scroll_rows,
  input  logic               in_shift,
  input  logic [9:0]         in_read_index,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [2:0]         out_status,
  output logic               out_dropped_oldest,
  output logic               out_any_printed,
  output logic               out_at_top,
  output logic [7:0]         out_frame_byte
);
  import psc_pkg::*;

  // command and status between sequencer and datapath
  psc_cmd_t cmd;
  psc_sts_t sts;

  // sequencer: accepts words, walks clear, frames, rows and pixels
  psc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_cmd   (in_cmd),
    .in_ready (in_ready),
    .cmd      (cmd),
    .sts      (sts)
  );

  // datapath: ring state, memories, pixel pipeline and output register
  psc_dp #(
    .RING_DEPTH     (RING_DEPTH),
    .SLOT_BYTES     (SLOT_BYTES),
    .SCREEN_COLUMNS (SCREEN_COLUMNS)
  ) u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .sts                (sts),
    .in_cmd             (in_cmd),
    .in_x_offset        (in_x_offset),
    .in_frame_width     (in_frame_width),
    .in_frame_height    (in_frame_height),
    .in_bytes_per_line  (in_bytes_per_line),
    .in_data_byte       (in_data_byte),
    .in_scroll_rows     (in_scroll_rows),
    .in_shift           (in_shift),
    .in_read_index      (in_read_index),
    .out_ready          (out_ready),
    .out_valid          (out_valid),
    .out_status         (out_status),
    .out_dropped_oldest (out_dropped_oldest),
    .out_any_printed    (out_any_printed),
    .out_at_top         (out_at_top),
    .out_frame_byte     (out_frame_byte)
  );

endmodule
